>>> design/hft_pkg.sv
// shared types and constants of the hopscotch flow table
package hft_pkg;

	localparam int HASH_W     = 32;
	localparam int FID_IN_W   = 16;
	localparam int SLOT_W     = 10;
	localparam int DISP_OUT_W = 4;
	localparam int S_DATA_W   = HASH_W + FID_IN_W;
	localparam int M_DATA_W   = 2 + SLOT_W + DISP_OUT_W;
	localparam int FAR_HOODS  = 4;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_EMPTY  = 2'd1,
		ST_NO_MOVE   = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic {
		MODE_INSERT = 1'b0,
		MODE_CLEAR  = 1'b1
	} mode_t;

endpackage

>>> design/hopscotch_flow_table_core.sv
// hopscotch flow table: insert and clear of flow entries over a single-port scan sequencer
//
// After reset the block sweeps the entry memory once, one slot per cycle, to mark every
// slot invalid; s_tready stays low meanwhile. An item is then taken on a slave beat and
// answered by exactly one master beat. The home slot is the hash modulo TABLE_ENTRIES:
// free when TABLE_ENTRIES is a power of two, otherwise found in S_MOD by a reciprocal
// multiply and one corrective subtract. Every lookup goes through one memory read per
// cycle, so the slot scans set the rate: a clear scans up to NEIGHBORHOOD slots; an insert
// scans up to 5*NEIGHBORHOOD slots to find a free slot, plus up to NEIGHBORHOOD slots
// behind the hole for each entry it moves back, then writes the entry and hands over
// the result.
// One item is in work at a time; the result register lets the next item in while a
// finished beat still waits on m_tready.
module hopscotch_flow_table_core #(
	parameter int TABLE_ENTRIES = 1024,
	parameter int NEIGHBORHOOD  = 16,
	parameter int FLOW_ID_BITS  = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [hft_pkg::S_DATA_W-1:0]  s_tdata,   // hash[31:0], flow_id[47:32]
	input  logic [0:0]                    s_tuser,   // mode[0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hft_pkg::M_DATA_W-1:0]  m_tdata    // status[1:0], slot[11:2], displacement[15:12]
);
	import hft_pkg::*;

	localparam int AW    = $clog2(TABLE_ENTRIES);          // slot address bits
	localparam int DW    = $clog2(NEIGHBORHOOD);           // stored displacement bits
	localparam int SPAN  = (FAR_HOODS + 1) * NEIGHBORHOOD; // slots searched for a hole
	localparam int CW    = $clog2(SPAN + 1);               // scan distance / count bits
	localparam int CMP_W = (FLOW_ID_BITS > FID_IN_W) ? FLOW_ID_BITS : FID_IN_W;
	localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
	// reciprocal of TABLE_ENTRIES scaled so that it fits 32 bits
	localparam int          MOD_SH    = 31 + AW;
	localparam logic [31:0] MOD_RECIP = 32'((64'd1 << MOD_SH) / 64'(TABLE_ENTRIES));
	localparam logic [31:0] MOD_DIV   = 32'(TABLE_ENTRIES);

	typedef struct packed {
		logic                    vld;
		logic [DW-1:0]           disp;
		logic [FLOW_ID_BITS-1:0] fid;
	} entry_t;

	typedef enum logic [3:0] {
		S_INIT,     // clearing sweep after reset
		S_IDLE,
		S_MOD,      // hash remainder by reciprocal
		S_CSCAN,    // clear: look for the matching entry
		S_ISCAN,    // insert: look for the first free slot
		S_BSCAN,    // insert: look behind the hole for a movable entry
		S_MV_HOLE,  // copy the movable entry into the hole
		S_MV_SRC,   // vacate the moved entry's old slot
		S_PUT,      // write the new entry
		S_DONE      // hand the result to the output register
	} state_t;

	// storage
	entry_t      entry_mem [TABLE_ENTRIES];
	logic [31:0] hash_mem  [TABLE_ENTRIES];

	state_t               state_q;
	mode_t                mode_q;
	logic [HASH_W-1:0]    hash_q;
	logic [FID_IN_W-1:0]  fid_q;
	logic [1:0]           mod_cnt_q;
	logic [63:0]          mod_prod_q;
	logic [AW:0]          mod_rem_q;

	// scan pointer, issue count and limit
	logic [AW-1:0]        ptr_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        lim_q;

	// read in flight: address and scan distance of the data now on the memory output
	logic                 rd_pend_s1;
	logic [AW-1:0]        rd_addr_s1;
	logic [CW-1:0]        rd_dist_s1;
	entry_t               rd_ent_q;
	logic [HASH_W-1:0]    rd_hash_q;

	// hole being walked back toward home, and the entry being moved into it
	logic [AW-1:0]        hole_q;
	logic [CW-1:0]        dist_q;
	logic [AW-1:0]        src_q;
	logic [CW-1:0]        back_q;
	logic [DW-1:0]        mv_disp_q;
	logic [FLOW_ID_BITS-1:0] mv_fid_q;
	logic [HASH_W-1:0]    mv_hash_q;

	// result
	status_t              res_st_q;
	logic [AW-1:0]        res_slot_q;
	logic [CW-1:0]        res_disp_q;
	logic                 m_tvalid_q;
	status_t              out_st_q;
	logic [SLOT_W-1:0]    out_slot_q;
	logic [DISP_OUT_W-1:0] out_disp_q;

	// memory write port
	logic                 ent_we;
	logic [AW-1:0]        ent_wa;
	entry_t               ent_wd;
	logic                 hash_we;
	logic [HASH_W-1:0]    hash_wd;

	logic [AW-1:0]        ptr_inc;
	logic [31:0]          mod_quot;
	logic [31:0]          mod_diff;
	logic [AW-1:0]        rem_nxt;
	logic                 scan_st;
	logic                 scan_end;
	logic                 clr_hit;
	logic                 free_hit;
	logic                 mv_hit;
	logic                 hit;
	logic                 issue;
	logic                 out_load;
	logic [CW-1:0]        back_now;
	logic [CW-1:0]        dist_nxt;

	// slot NEIGHBORHOOD places behind a, with wraparound
	function automatic logic [AW-1:0] back_from(input logic [AW-1:0] a);
		if (a >= AW'(NEIGHBORHOOD))
			return a - AW'(NEIGHBORHOOD);
		else
			return a + AW'(TABLE_ENTRIES - NEIGHBORHOOD);
	endfunction

	assign ptr_inc = (ptr_q == AW'(TABLE_ENTRIES - 1)) ? '0 : ptr_q + 1'b1;

	// quotient estimate is low by at most one, so the remainder needs one subtract at most
	assign mod_quot = 32'(mod_prod_q >> MOD_SH);
	assign mod_diff = hash_q - mod_quot * MOD_DIV;
	assign rem_nxt  = (mod_rem_q >= (AW+1)'(TABLE_ENTRIES)) ?
		AW'(mod_rem_q - (AW+1)'(TABLE_ENTRIES)) : AW'(mod_rem_q);

	assign scan_st  = (state_q == S_CSCAN) || (state_q == S_ISCAN) || (state_q == S_BSCAN);
	assign scan_end = !rd_pend_s1 && (cnt_q == lim_q);
	assign back_now = CW'(NEIGHBORHOOD) - rd_dist_s1;

	assign clr_hit  = (state_q == S_CSCAN) && rd_pend_s1 && rd_ent_q.vld &&
		(rd_hash_q == hash_q) && (CMP_W'(rd_ent_q.fid) == CMP_W'(fid_q));
	assign free_hit = (state_q == S_ISCAN) && rd_pend_s1 && !rd_ent_q.vld;
	// a candidate may move only if it stays inside its own neighborhood
	assign mv_hit   = (state_q == S_BSCAN) && rd_pend_s1 && rd_ent_q.vld &&
		(back_now + CW'(rd_ent_q.disp) <= CW'(NEIGHBORHOOD - 1));
	assign hit      = clr_hit || free_hit || mv_hit;
	assign issue    = scan_st && !hit && (cnt_q < lim_q);
	assign dist_nxt = dist_q - back_q;
	// result register takes the finished beat when empty or draining
	assign out_load = (state_q == S_DONE) && (!m_tvalid_q || m_tready);

	// write port select
	always_comb begin
		ent_we  = 1'b0;
		ent_wa  = hole_q;
		ent_wd  = '0;
		hash_we = 1'b0;
		hash_wd = hash_q;
		unique case (state_q)
			S_INIT: begin
				ent_we = 1'b1;
				ent_wa = ptr_q;
			end
			S_CSCAN: begin
				ent_we = clr_hit;
				ent_wa = rd_addr_s1;
			end
			S_MV_HOLE: begin
				ent_we  = 1'b1;
				ent_wd  = '{vld: 1'b1, disp: mv_disp_q, fid: mv_fid_q};
				hash_we = 1'b1;
				hash_wd = mv_hash_q;
			end
			S_MV_SRC: begin
				ent_we = 1'b1;
				ent_wa = src_q;
			end
			S_PUT: begin
				ent_we  = 1'b1;
				ent_wd  = '{vld: 1'b1, disp: DW'(dist_q), fid: FLOW_ID_BITS'(fid_q)};
				hash_we = 1'b1;
			end
			default: begin
				ent_we = 1'b0;
			end
		endcase
	end

	// entry and hash memories, registered read at the scan pointer
	always_ff @(posedge clk) begin
		if (ent_we)
			entry_mem[ent_wa] <= ent_wd;
		if (hash_we)
			hash_mem[ent_wa] <= hash_wd;
		rd_ent_q  <= entry_mem[ptr_q];
		rd_hash_q <= hash_mem[ptr_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			ptr_q      <= '0;
			cnt_q      <= '0;
			lim_q      <= '0;
			rd_pend_s1 <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_pend_s1 <= issue;
			if (issue) begin
				rd_addr_s1 <= ptr_q;
				rd_dist_s1 <= cnt_q;
				cnt_q      <= cnt_q + 1'b1;
				ptr_q      <= ptr_inc;
			end
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				S_INIT: begin
					ptr_q <= ptr_inc;
					if (ptr_q == AW'(TABLE_ENTRIES - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_tvalid) begin
						mode_q    <= mode_t'(s_tuser[0]);
						hash_q    <= s_tdata[HASH_W-1:0];
						fid_q     <= s_tdata[S_DATA_W-1:HASH_W];
						mod_cnt_q <= '0;
						if (IS_POW2) begin
							ptr_q <= s_tdata[AW-1:0];
							cnt_q <= '0;
							if (mode_t'(s_tuser[0]) == MODE_CLEAR) begin
								lim_q   <= CW'(NEIGHBORHOOD);
								state_q <= S_CSCAN;
							end else begin
								lim_q   <= CW'(SPAN);
								state_q <= S_ISCAN;
							end
						end else begin
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					mod_cnt_q <= mod_cnt_q + 1'b1;
					if (mod_cnt_q == 2'd0)
						mod_prod_q <= 64'(hash_q) * 64'(MOD_RECIP);
					if (mod_cnt_q == 2'd1)
						mod_rem_q <= (AW+1)'(mod_diff);
					if (mod_cnt_q == 2'd2) begin
						ptr_q <= rem_nxt;
						cnt_q <= '0;
						if (mode_q == MODE_CLEAR) begin
							lim_q   <= CW'(NEIGHBORHOOD);
							state_q <= S_CSCAN;
						end else begin
							lim_q   <= CW'(SPAN);
							state_q <= S_ISCAN;
						end
					end
				end
				S_CSCAN: begin
					res_slot_q <= '0;
					res_disp_q <= '0;
					if (clr_hit) begin
						res_st_q <= ST_OK;
						state_q  <= S_DONE;
					end else if (scan_end) begin
						res_st_q <= ST_NOT_FOUND;
						state_q  <= S_DONE;
					end
				end
				S_ISCAN: begin
					if (free_hit) begin
						hole_q <= rd_addr_s1;
						dist_q <= rd_dist_s1;
						if (rd_dist_s1 < CW'(NEIGHBORHOOD)) begin
							state_q <= S_PUT;
						end else begin
							ptr_q   <= back_from(rd_addr_s1);
							cnt_q   <= '0;
							lim_q   <= CW'(NEIGHBORHOOD);
							state_q <= S_BSCAN;
						end
					end else if (scan_end) begin
						res_st_q   <= ST_NO_EMPTY;
						res_slot_q <= '0;
						res_disp_q <= '0;
						state_q    <= S_DONE;
					end
				end
				S_BSCAN: begin
					if (mv_hit) begin
						src_q     <= rd_addr_s1;
						back_q    <= back_now;
						mv_disp_q <= DW'(CW'(rd_ent_q.disp) + back_now);
						mv_fid_q  <= rd_ent_q.fid;
						mv_hash_q <= rd_hash_q;
						state_q   <= S_MV_HOLE;
					end else if (scan_end) begin
						// entries already moved stay moved
						res_st_q   <= ST_NO_MOVE;
						res_slot_q <= '0;
						res_disp_q <= '0;
						state_q    <= S_DONE;
					end
				end
				S_MV_HOLE: begin
					state_q <= S_MV_SRC;
				end
				S_MV_SRC: begin
					dist_q <= dist_nxt;
					hole_q <= src_q;
					if (dist_nxt < CW'(NEIGHBORHOOD)) begin
						state_q <= S_PUT;
					end else begin
						ptr_q   <= back_from(src_q);
						cnt_q   <= '0;
						lim_q   <= CW'(NEIGHBORHOOD);
						state_q <= S_BSCAN;
					end
				end
				S_PUT: begin
					res_st_q   <= ST_OK;
					res_slot_q <= hole_q;
					res_disp_q <= dist_q;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (out_load) begin
						out_st_q   <= res_st_q;
						out_slot_q <= SLOT_W'(res_slot_q);
						out_disp_q <= DISP_OUT_W'(res_disp_q);
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_disp_q, out_slot_q, out_st_q};

endmodule

>>> design/hft_checker.sv
// port-level checks of the hopscotch flow table and their bind
module hft_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [hft_pkg::M_DATA_W-1:0] m_tdata
);
	import hft_pkg::*;

	logic [1:0] outstanding_q;
	logic       acc;
	logic       del;

	assign acc = s_tvalid && s_tready;
	assign del = m_tvalid && m_tready;

	// items taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			outstanding_q <= '0;
		else if (acc && !del)
			outstanding_q <= outstanding_q + 1'b1;
		else if (del && !acc)
			outstanding_q <= outstanding_q - 1'b1;
	end

	// failed results carry no slot and no displacement; clear results also carry none, but this check covers failures only
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (status_t'(m_tdata[1:0]) != ST_OK) |-> m_tdata[M_DATA_W-1:2] == '0)
		else $error("result with failure status has nonzero slot or displacement");

	// one item in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !s_tready)
		else $error("input ready right after an accepted beat");

	// no result beat without an item behind it
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> outstanding_q != 2'd0)
		else $error("result beat with no item outstanding");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result beat dropped or changed");

endmodule

bind hopscotch_flow_table_core hft_checker u_hft_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
